// ----- sv/htm_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and the octant root table for the htm point index
// no dependencies

package htm_pkg;

  localparam int MAX_LEVEL_DEF = 24;
  localparam int FRAC_BITS_DEF = 30;
  localparam int RSQRT_STEPS   = 6;
  localparam int IDX_W         = 52;
  localparam int LVL_W         = 5;
  localparam int COMP_W        = 32;
  localparam logic [LVL_W-1:0] LEVEL_RESET = LVL_W'(20);

  typedef struct packed {
    logic [2:0][COMP_W-1:0] vec;
    logic [IDX_W-1:0]       idx;
    logic [LVL_W-1:0]       rem;
  } htm_item_t;

  // corners of the eight root triangles: p0 xyz, p1 xyz, p2 xyz
  localparam logic signed [1:0] ROOT_CORNER [0:7][0:8] = '{
    '{ 2'sd1,  2'sd0,  2'sd0,  2'sd0,  2'sd0, -2'sd1,  2'sd0,  2'sd1,  2'sd0},
    '{ 2'sd0,  2'sd1,  2'sd0,  2'sd0,  2'sd0, -2'sd1, -2'sd1,  2'sd0,  2'sd0},
    '{-2'sd1,  2'sd0,  2'sd0,  2'sd0,  2'sd0, -2'sd1,  2'sd0, -2'sd1,  2'sd0},
    '{ 2'sd0, -2'sd1,  2'sd0,  2'sd0,  2'sd0, -2'sd1,  2'sd1,  2'sd0,  2'sd0},
    '{ 2'sd1,  2'sd0,  2'sd0,  2'sd0,  2'sd0,  2'sd1,  2'sd0, -2'sd1,  2'sd0},
    '{ 2'sd0, -2'sd1,  2'sd0,  2'sd0,  2'sd0,  2'sd1, -2'sd1,  2'sd0,  2'sd0},
    '{-2'sd1,  2'sd0,  2'sd0,  2'sd0,  2'sd0,  2'sd1,  2'sd0,  2'sd1,  2'sd0},
    '{ 2'sd0,  2'sd1,  2'sd0,  2'sd0,  2'sd0,  2'sd1,  2'sd1,  2'sd0,  2'sd0}
  };

endpackage

// ----- sv/htm_mul.sv -----
`timescale 1ns / 1ps
// signed multiplier, one 16-bit digit of b per cycle, most significant first
// depends on htm_pkg

module htm_mul import htm_pkg::*; #(
  parameter int AW = 65,
  parameter int BW = 34
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [AW-1:0]     a,
  input  logic signed [BW-1:0]     b,
  output logic                     done,
  output logic signed [AW+BW-1:0]  p
);

  localparam int ND = (BW + 15) / 16;
  localparam int EW = ND * 16;
  localparam int PW = AW + BW;
  localparam int CW = $clog2(ND + 1);

  logic signed [AW-1:0] a_r;
  logic [EW-1:0]        b_r;
  logic signed [PW-1:0] acc_r;
  logic [CW-1:0]        cnt_r;
  logic                 first_r;
  logic                 done_r;

  logic signed [16:0]    dig;
  logic signed [AW+16:0] pp;
  logic signed [PW-1:0]  acc_nxt;

  always_comb begin
    dig     = first_r ? $signed({b_r[EW-1], b_r[EW-1 -: 16]})
                      : $signed({1'b0, b_r[EW-1 -: 16]});
    pp      = a_r * dig;
    acc_nxt = (acc_r <<< 16) + PW'(pp);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      done_r  <= 1'b0;
      first_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r     <= a;
        b_r     <= EW'(b);
        acc_r   <= '0;
        cnt_r   <= CW'(ND);
        first_r <= 1'b1;
      end else if (cnt_r != '0) begin
        acc_r   <= acc_nxt;
        b_r     <= b_r << 16;
        first_r <= 1'b0;
        cnt_r   <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule

// ----- sv/htm_root.sv -----
`timescale 1ns / 1ps
// root stage: picks the octant triangle and seeds the index and vertices
// depends on htm_pkg

module htm_root import htm_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [3*COMP_W-1:0]           in_vec,
  input  logic [LVL_W-1:0]              in_lvl,
  output logic                          out_valid,
  input  logic                          out_ready,
  output htm_item_t                     out_item,
  output logic [9*(FRAC_BITS+2)-1:0]    out_vtx
);

  localparam int VW = FRAC_BITS + 2;
  localparam logic signed [VW-1:0] ONE_Q = VW'(1) <<< FRAC_BITS;

  logic                     vld_r;
  htm_item_t                item_r;
  logic [9*VW-1:0]          vtx_r;

  logic signed [COMP_W-1:0] vx, vy, vz;
  logic [2:0]               root;
  logic [9*VW-1:0]          vtx_nxt;

  always_comb begin
    vx = $signed(in_vec[0 +: COMP_W]);
    vy = $signed(in_vec[COMP_W +: COMP_W]);
    vz = $signed(in_vec[2*COMP_W +: COMP_W]);
    if (vz < 0) begin
      if (vy > 0)       root = (vx > 0)  ? 3'd0 : 3'd1;
      else if (vy == 0) root = (vx >= 0) ? 3'd0 : 3'd2;
      else              root = (vx < 0)  ? 3'd2 : 3'd3;
    end else begin
      if (vy > 0)       root = (vx > 0)  ? 3'd7 : 3'd6;
      else if (vy == 0) root = (vx >= 0) ? 3'd7 : 3'd5;
      else              root = (vx < 0)  ? 3'd5 : 3'd4;
    end
    for (int i = 0; i < 9; i++) begin
      case (ROOT_CORNER[root][i])
        2'sd1:   vtx_nxt[i*VW +: VW] = ONE_Q;
        -2'sd1:  vtx_nxt[i*VW +: VW] = -ONE_Q;
        default: vtx_nxt[i*VW +: VW] = '0;
      endcase
    end
  end

  assign in_ready = !vld_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        vld_r <= in_valid;
      end
    end
    if (in_valid && in_ready) begin
      item_r.vec <= in_vec;
      item_r.idx <= IDX_W'(root) + IDX_W'(8);
      item_r.rem <= in_lvl;
      vtx_r      <= vtx_nxt;
    end
  end

  assign out_valid = vld_r;
  assign out_item  = item_r;
  assign out_vtx   = vtx_r;

endmodule

// ----- sv/htm_level_cell.sv -----
`timescale 1ns / 1ps
// one subdivision level: midpoints with rsqrt, orientation tests, child pick
// depends on htm_pkg and htm_mul

module htm_level_cell import htm_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  htm_item_t                     in_item,
  input  logic [9*(FRAC_BITS+2)-1:0]    in_vtx,
  output logic                          out_valid,
  input  logic                          out_ready,
  output htm_item_t                     out_item,
  output logic [9*(FRAC_BITS+2)-1:0]    out_vtx
);

  localparam int VW = FRAC_BITS + 2;
  localparam int QW = FRAC_BITS + 4;
  localparam int AW = 2 * VW + 1;
  localparam int BW = (QW > COMP_W) ? QW : COMP_W;
  localparam int PW = AW + BW;
  localparam int DW = PW + 2;
  localparam int IW = $clog2(RSQRT_STEPS + 1);
  localparam logic signed [PW-1:0] HALF    = PW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [QW-1:0] THREE_Q = QW'(3) <<< FRAC_BITS;
  localparam logic signed [QW-1:0] Y_INIT  = QW'((64'd151 << FRAC_BITS) >> 8);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PREP = 5'b00010,
    ST_MID  = 5'b00100,
    ST_INS  = 5'b01000,
    ST_OUT  = 5'b10000
  } st_t;

  typedef enum logic [2:0] {
    TK_M01, TK_M20, TK_M12, TK_IN0, TK_IN1, TK_IN2
  } tk_t;

  typedef enum logic [2:0] {
    PH_SQ, PH_RS, PH_SC, PH_CRS, PH_DOT
  } ph_t;

  function automatic logic [1:0] nx1(input logic [1:0] k);
    case (k)
      2'd0:    nx1 = 2'd1;
      2'd1:    nx1 = 2'd2;
      default: nx1 = 2'd0;
    endcase
  endfunction

  function automatic logic [1:0] nx2(input logic [1:0] k);
    case (k)
      2'd0:    nx2 = 2'd2;
      2'd1:    nx2 = 2'd0;
      default: nx2 = 2'd1;
    endcase
  endfunction

  st_t                   st_r;
  tk_t                   tk_r;
  ph_t                   ph_r;
  logic [1:0]            k_r;
  logic [1:0]            sub_r;
  logic [IW-1:0]         it_r;
  logic                  wait_r;
  htm_item_t             item_r;
  logic signed [VW-1:0]  p_r   [9];
  logic signed [VW-1:0]  m01_r [3];
  logic signed [VW-1:0]  m20_r [3];
  logic signed [VW-1:0]  m12_r [3];
  logic signed [QW-1:0]  s_r   [3];
  logic signed [QW-1:0]  n2_r, y_r, yy_r, t_r;
  logic signed [AW-1:0]  c_r   [3];
  logic signed [AW-1:0]  tmp_r;
  logic signed [DW-1:0]  d_r;

  logic signed [VW-1:0]  pa [3];
  logic signed [VW-1:0]  pb [3];
  logic signed [AW-1:0]  mul_a;
  logic signed [BW-1:0]  mul_b;
  logic                  mul_start;
  logic                  mul_done;
  logic signed [PW-1:0]  mul_p;
  logic signed [PW-1:0]  pr;
  logic signed [PW-1:0]  rsh;
  logic signed [QW-1:0]  rq;
  logic signed [QW-1:0]  yh;
  logic signed [DW-1:0]  dsum;
  logic                  is_in;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      case (tk_r)
        TK_M01:  begin pa[i] = p_r[i];     pb[i] = p_r[3+i]; end
        TK_M20:  begin pa[i] = p_r[6+i];   pb[i] = p_r[i];   end
        TK_M12:  begin pa[i] = p_r[3+i];   pb[i] = p_r[6+i]; end
        TK_IN0:  begin pa[i] = m01_r[i];   pb[i] = m20_r[i]; end
        TK_IN1:  begin pa[i] = m12_r[i];   pb[i] = m01_r[i]; end
        default: begin pa[i] = m20_r[i];   pb[i] = m12_r[i]; end
      endcase
    end
  end

  always_comb begin
    case (ph_r)
      PH_SQ: begin
        mul_a = AW'(s_r[k_r]);
        mul_b = BW'(s_r[k_r]);
      end
      PH_RS: begin
        case (sub_r)
          2'd0:    begin mul_a = AW'(y_r);  mul_b = BW'(y_r);  end
          2'd1:    begin mul_a = AW'(n2_r); mul_b = BW'(yy_r); end
          default: begin mul_a = AW'(y_r);  mul_b = BW'(t_r);  end
        endcase
      end
      PH_SC: begin
        mul_a = AW'(s_r[k_r]);
        mul_b = BW'(y_r);
      end
      PH_CRS: begin
        if (sub_r == 2'd0) begin
          mul_a = AW'(pa[nx1(k_r)]);
          mul_b = BW'(pb[nx2(k_r)]);
        end else begin
          mul_a = AW'(pa[nx2(k_r)]);
          mul_b = BW'(pb[nx1(k_r)]);
        end
      end
      default: begin
        mul_a = c_r[k_r];
        mul_b = BW'($signed(item_r.vec[k_r]));
      end
    endcase
  end

  assign mul_start = ((st_r == ST_MID) || (st_r == ST_INS)) && !wait_r;

  htm_mul #(.AW(AW), .BW(BW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  always_comb begin
    pr    = mul_p + HALF;
    rsh   = pr >>> FRAC_BITS;
    rq    = rsh[QW-1:0];
    yh    = rq + $signed({{(QW-1){1'b0}}, rq[QW-1]});
    dsum  = d_r + DW'(mul_p);
    is_in = !dsum[DW-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      tk_r   <= TK_M01;
      ph_r   <= PH_SQ;
      k_r    <= '0;
      sub_r  <= '0;
      it_r   <= '0;
      wait_r <= 1'b0;
    end else begin
      if (mul_start) begin
        wait_r <= 1'b1;
      end
      case (st_r)
        ST_IDLE: begin
          if (in_valid) begin
            item_r <= in_item;
            for (int i = 0; i < 9; i++) begin
              p_r[i] <= $signed(in_vtx[i*VW +: VW]);
            end
            tk_r <= TK_M01;
            st_r <= (in_item.rem == '0) ? ST_OUT : ST_PREP;
          end
        end
        ST_PREP: begin
          for (int i = 0; i < 3; i++) begin
            s_r[i] <= QW'(pa[i]) + QW'(pb[i]);
          end
          n2_r   <= '0;
          y_r    <= Y_INIT;
          d_r    <= '0;
          k_r    <= '0;
          sub_r  <= '0;
          it_r   <= '0;
          wait_r <= 1'b0;
          if (tk_r inside {TK_IN0, TK_IN1, TK_IN2}) begin
            ph_r <= PH_CRS;
            st_r <= ST_INS;
          end else begin
            ph_r <= PH_SQ;
            st_r <= ST_MID;
          end
        end
        ST_MID: begin
          if (mul_done) begin
            wait_r <= 1'b0;
            case (ph_r)
              PH_SQ: begin
                n2_r <= n2_r + rq;
                if (k_r == 2'd2) begin
                  ph_r  <= PH_RS;
                  sub_r <= '0;
                  it_r  <= '0;
                end else begin
                  k_r <= k_r + 2'd1;
                end
              end
              PH_RS: begin
                case (sub_r)
                  2'd0: begin
                    yy_r  <= rq;
                    sub_r <= 2'd1;
                  end
                  2'd1: begin
                    t_r   <= THREE_Q - rq;
                    sub_r <= 2'd2;
                  end
                  default: begin
                    y_r   <= yh >>> 1;
                    sub_r <= 2'd0;
                    if (it_r == IW'(RSQRT_STEPS - 1)) begin
                      ph_r <= PH_SC;
                      k_r  <= '0;
                    end else begin
                      it_r <= it_r + IW'(1);
                    end
                  end
                endcase
              end
              default: begin
                case (tk_r)
                  TK_M01:  m01_r[k_r] <= rq[VW-1:0];
                  TK_M20:  m20_r[k_r] <= rq[VW-1:0];
                  default: m12_r[k_r] <= rq[VW-1:0];
                endcase
                if (k_r == 2'd2) begin
                  st_r <= ST_PREP;
                  case (tk_r)
                    TK_M01:  tk_r <= TK_M20;
                    TK_M20:  tk_r <= TK_IN0;
                    default: tk_r <= TK_IN1;
                  endcase
                end else begin
                  k_r <= k_r + 2'd1;
                end
              end
            endcase
          end
        end
        ST_INS: begin
          if (mul_done) begin
            wait_r <= 1'b0;
            if (ph_r == PH_CRS) begin
              if (sub_r == 2'd0) begin
                tmp_r <= mul_p[AW-1:0];
                sub_r <= 2'd1;
              end else begin
                c_r[k_r] <= tmp_r - mul_p[AW-1:0];
                sub_r    <= 2'd0;
                if (k_r == 2'd2) begin
                  ph_r <= PH_DOT;
                  k_r  <= '0;
                end else begin
                  k_r <= k_r + 2'd1;
                end
              end
            end else begin
              d_r <= dsum;
              if (k_r != 2'd2) begin
                k_r <= k_r + 2'd1;
              end else begin
                case (tk_r)
                  TK_IN0: begin
                    if (is_in) begin
                      for (int i = 0; i < 3; i++) begin
                        p_r[3+i] <= m01_r[i];
                        p_r[6+i] <= m20_r[i];
                      end
                      item_r.idx <= {item_r.idx[IDX_W-3:0], 2'd0};
                      item_r.rem <= item_r.rem - LVL_W'(1);
                      st_r       <= ST_OUT;
                    end else begin
                      tk_r <= TK_M12;
                      st_r <= ST_PREP;
                    end
                  end
                  TK_IN1: begin
                    if (is_in) begin
                      for (int i = 0; i < 3; i++) begin
                        p_r[i]   <= p_r[3+i];
                        p_r[3+i] <= m12_r[i];
                        p_r[6+i] <= m01_r[i];
                      end
                      item_r.idx <= {item_r.idx[IDX_W-3:0], 2'd1};
                      item_r.rem <= item_r.rem - LVL_W'(1);
                      st_r       <= ST_OUT;
                    end else begin
                      tk_r <= TK_IN2;
                      st_r <= ST_PREP;
                    end
                  end
                  default: begin
                    for (int i = 0; i < 3; i++) begin
                      if (is_in) begin
                        p_r[i]   <= p_r[6+i];
                        p_r[3+i] <= m20_r[i];
                        p_r[6+i] <= m12_r[i];
                      end else begin
                        p_r[i]   <= m12_r[i];
                        p_r[3+i] <= m20_r[i];
                        p_r[6+i] <= m01_r[i];
                      end
                    end
                    item_r.idx <= {item_r.idx[IDX_W-3:0], is_in ? 2'd2 : 2'd3};
                    item_r.rem <= item_r.rem - LVL_W'(1);
                    st_r       <= ST_OUT;
                  end
                endcase
              end
            end
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            st_r <= ST_IDLE;
          end
        end
        default: begin
          st_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready  = (st_r == ST_IDLE);
  assign out_valid = (st_r == ST_OUT);
  assign out_item  = item_r;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      out_vtx[i*VW +: VW] = p_r[i];
    end
  end

endmodule

// ----- sv/htm_point_index.sv -----
`timescale 1ns / 1ps
// htm point index: unit vector in, mesh index at the configured level out
// depends on htm_pkg, htm_root, htm_level_cell, htm_mul
//
// Usage:
//   in_tdata carries the vector (x, y, z as signed Q2.30); out_tdata carries
//   the mesh index. Each transfer in gives exactly one transfer out, in order.
//   cfg_wen/cfg_wdata set the subdivision level (reset 20, above MAX_LEVEL
//   counts as MAX_LEVEL); write it only while the block is empty.
//   The vector passes a root stage then a row of MAX_LEVEL level cells. A
//   cell that still has a level to do computes two or three midpoints of
//   24 multiplies and one to three orientation tests of 9 multiplies, each
//   multiply stepping through ND = ceil(max(FRAC_BITS+4, 32)/16) digits on
//   the cell's multiplier; other cells pass the item on unchanged. The row
//   holds one item per cell, so items in different cells are worked on at
//   once, but a cell takes a new item only after it has handed on its last.
//   Reset empties every cell and the output register. If the receiver
//   stalls, the result is held in the output register and items back up
//   through the cells until in_tready falls.

module htm_point_index import htm_pkg::*; #(
  parameter int MAX_LEVEL = MAX_LEVEL_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [95:0]      in_tdata,   // vec_x, vec_y, vec_z
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [55:0]      out_tdata,  // mesh_index, zero pad
  input  logic             cfg_wen,
  input  logic [LVL_W-1:0] cfg_wdata
);

  localparam int VW = FRAC_BITS + 2;

  logic [LVL_W-1:0] lvl_r;
  logic [LVL_W-1:0] lvl_sat;

  logic             c_valid [MAX_LEVEL+1];
  logic             c_ready [MAX_LEVEL+1];
  htm_item_t        c_item  [MAX_LEVEL+1];
  logic [9*VW-1:0]  c_vtx   [MAX_LEVEL+1];

  logic             out_vld_r;
  logic [IDX_W-1:0] out_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r <= LEVEL_RESET;
    end else if (cfg_wen) begin
      lvl_r <= cfg_wdata;
    end
  end

  assign lvl_sat = (lvl_r > LVL_W'(MAX_LEVEL)) ? LVL_W'(MAX_LEVEL) : lvl_r;

  htm_root #(.FRAC_BITS(FRAC_BITS)) u_root (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_vec    (in_tdata),
    .in_lvl    (lvl_sat),
    .out_valid (c_valid[0]),
    .out_ready (c_ready[0]),
    .out_item  (c_item[0]),
    .out_vtx   (c_vtx[0])
  );

  for (genvar g = 0; g < MAX_LEVEL; g++) begin : g_cell
    htm_level_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (c_valid[g]),
      .in_ready  (c_ready[g]),
      .in_item   (c_item[g]),
      .in_vtx    (c_vtx[g]),
      .out_valid (c_valid[g+1]),
      .out_ready (c_ready[g+1]),
      .out_item  (c_item[g+1]),
      .out_vtx   (c_vtx[g+1])
    );
  end

  assign c_ready[MAX_LEVEL] = !out_vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (c_ready[MAX_LEVEL]) begin
      out_vld_r <= c_valid[MAX_LEVEL];
    end
    if (c_ready[MAX_LEVEL] && c_valid[MAX_LEVEL]) begin
      out_idx_r <= c_item[MAX_LEVEL].idx;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'd0, out_idx_r};

endmodule

// ----- sim/htm_point_index_tb.sv -----
`timescale 1ns / 1ps
// testbench for htm_point_index: directed table then random vectors, each result
// checked against a table index or a fixed-point index model; depends on htm_pkg

module htm_point_index_tb;
  import htm_pkg::*;

  localparam longint ONE_Q = 64'sd1 <<< FRAC_BITS_DEF;

  typedef longint tri_vec_t [0:2];

  typedef struct {
    logic [LVL_W-1:0] lvl;
    logic [31:0]      x, y, z;
    bit               typed;
    logic [IDX_W-1:0] idx;
  } dir_row_t;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [95:0]      in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [55:0]      out_tdata;
  logic             cfg_wen;
  logic [LVL_W-1:0] cfg_wdata;

  logic [IDX_W-1:0] pending_idx[$];
  logic [LVL_W-1:0] cur_level;
  int               errors;
  int               send_idle;
  int               recv_idle;

  htm_point_index DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #80ms;
    $display("Test completed with failures");
    $finish;
  end

  // rounded fixed-point product, ties towards plus infinity
  function automatic longint qmul(longint a, longint b);
    logic signed [127:0] p;
    p = 128'(a) * 128'(b);
    p = p + (128'sd1 <<< (FRAC_BITS_DEF - 1));
    p = p >>> FRAC_BITS_DEF;
    return longint'(p[63:0]);
  endfunction

  function automatic tri_vec_t norm_mid(tri_vec_t a, tri_vec_t b);
    tri_vec_t s, m;
    longint n2, y, t;
    n2 = 0;
    for (int k = 0; k < 3; k++) begin
      s[k] = a[k] + b[k];
      n2 = n2 + qmul(s[k], s[k]);
    end
    y = 64'sd151 <<< (FRAC_BITS_DEF - 8);
    for (int k = 0; k < RSQRT_STEPS; k++) begin
      t = qmul(n2, qmul(y, y));
      t = 3 * ONE_Q - t;
      y = qmul(y, t) / 2;
    end
    for (int k = 0; k < 3; k++) m[k] = qmul(s[k], y);
    return m;
  endfunction

  // orientation of v against edge a-b, zero counts as inside
  function automatic bit on_inner_side(tri_vec_t v, tri_vec_t a, tri_vec_t b);
    logic signed [127:0] cx, cy, cz, d;
    cx = 128'(a[1]) * 128'(b[2]) - 128'(a[2]) * 128'(b[1]);
    cy = 128'(a[2]) * 128'(b[0]) - 128'(a[0]) * 128'(b[2]);
    cz = 128'(a[0]) * 128'(b[1]) - 128'(a[1]) * 128'(b[0]);
    d = 128'(v[0]) * cx + 128'(v[1]) * cy + 128'(v[2]) * cz;
    return !d[127];
  endfunction

  function automatic logic [IDX_W-1:0] mesh_index(logic [31:0] x, logic [31:0] y,
                                                  logic [31:0] z, logic [LVL_W-1:0] lvl);
    tri_vec_t v, p0, p1, p2, m01, m20, m12;
    int root, depth;
    logic [63:0] idx;
    v[0] = longint'($signed(x));
    v[1] = longint'($signed(y));
    v[2] = longint'($signed(z));
    if (v[2] < 0) begin
      if (v[1] > 0) root = (v[0] > 0) ? 0 : 1;
      else if (v[1] == 0) root = (v[0] >= 0) ? 0 : 2;
      else root = (v[0] < 0) ? 2 : 3;
    end else begin
      if (v[1] > 0) root = (v[0] > 0) ? 7 : 6;
      else if (v[1] == 0) root = (v[0] >= 0) ? 7 : 5;
      else root = (v[0] < 0) ? 5 : 4;
    end
    for (int k = 0; k < 3; k++) begin
      p0[k] = longint'(ROOT_CORNER[root][k]) * ONE_Q;
      p1[k] = longint'(ROOT_CORNER[root][3+k]) * ONE_Q;
      p2[k] = longint'(ROOT_CORNER[root][6+k]) * ONE_Q;
    end
    idx = 64'(root + 8);
    depth = (lvl > MAX_LEVEL_DEF) ? MAX_LEVEL_DEF : int'(lvl);
    for (int l = 0; l < depth; l++) begin
      m01 = norm_mid(p0, p1);
      m20 = norm_mid(p2, p0);
      idx = idx << 2;
      if (on_inner_side(v, m01, m20)) begin
        p1 = m01; p2 = m20;
      end else begin
        m12 = norm_mid(p1, p2);
        if (on_inner_side(v, m12, m01)) begin
          p0 = p1; p1 = m12; p2 = m01; idx += 1;
        end else if (on_inner_side(v, m20, m12)) begin
          p0 = p2; p1 = m20; p2 = m12; idx += 2;
        end else begin
          p0 = m12; p1 = m20; p2 = m01; idx += 3;
        end
      end
    end
    return idx[IDX_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      out_tready <= ($urandom_range(99) >= recv_idle);
      if (out_tvalid && out_tready) begin
        if (pending_idx.size() == 0) begin
          $error("mesh_index: unexpected transfer, actual %h", out_tdata[IDX_W-1:0]);
          errors++;
        end else begin
          if (out_tdata[IDX_W-1:0] !== pending_idx[0]) begin
            $error("mesh_index: expected %h, actual %h", pending_idx[0],
                   out_tdata[IDX_W-1:0]);
            errors++;
          end
          void'(pending_idx.pop_front());
        end
      end
    end
  end

  task automatic drain();
    while (pending_idx.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_level(logic [LVL_W-1:0] lvl);
    drain();
    cfg_wen   <= 1'b1;
    cfg_wdata <= lvl;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    cur_level = lvl;
    @(posedge clk);
  endtask

  task automatic send_vec(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                          bit typed, logic [IDX_W-1:0] idx);
    in_tvalid <= 1'b1;
    in_tdata  <= {z, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_idx.push_back(typed ? idx : mesh_index(x, y, z, cur_level));
    if ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(9))
      0: return 32'h0;
      1: return 32'h4000_0000;
      2: return 32'hc000_0000;
      3: return $urandom;
      4: return 32'($signed($urandom_range(0, 16)) - 8);
      default: return $urandom_range(0, 32'h4000_0000) * (($urandom_range(1)) ? 1 : -1);
    endcase
  endfunction

  dir_row_t dir_rows[] = '{
    '{5'd20, 32'h0,         32'h0,         32'h0,         1'b1, 52'hf << 40},
    '{5'd20, 32'h4000_0000, 32'h0,         32'h0,         1'b0, '0},
    '{5'd20, 32'h0,         32'hc000_0000, 32'h0,         1'b0, '0},
    '{5'd20, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b0, '0},
    '{5'd20, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b0, '0},
    '{5'd20, 32'h1,         32'h1,         32'hffff_ffff, 1'b0, '0},
    '{5'd20, 32'h24f3_4e5d, 32'h24f3_4e5d, 32'h24f3_4e5d, 1'b0, '0},
    '{5'd0,  32'h1,         32'h1,         32'hffff_ffff, 1'b1, 52'd8},
    '{5'd0,  32'hffff_ffff, 32'h1,         32'hffff_ffff, 1'b1, 52'd9},
    '{5'd0,  32'h0,         32'h0,         32'hffff_ffff, 1'b1, 52'd8},
    '{5'd0,  32'hffff_ffff, 32'h0,         32'hffff_ffff, 1'b1, 52'd10},
    '{5'd0,  32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 52'd10},
    '{5'd0,  32'h1,         32'hffff_ffff, 32'hffff_ffff, 1'b1, 52'd11},
    '{5'd0,  32'h1,         32'h1,         32'h0,         1'b1, 52'd15},
    '{5'd0,  32'hffff_ffff, 32'h1,         32'h0,         1'b1, 52'd14},
    '{5'd0,  32'hffff_ffff, 32'h0,         32'h0,         1'b1, 52'd13},
    '{5'd0,  32'h1,         32'hffff_ffff, 32'h0,         1'b1, 52'd12},
    '{5'd0,  32'h0,         32'h0,         32'h0,         1'b1, 52'd15},
    '{5'd31, 32'h0,         32'h0,         32'h0,         1'b1, 52'hf << 48},
    '{5'd31, 32'h2000_0000, 32'hd000_0000, 32'h3000_0000, 1'b0, '0},
    '{5'd24, 32'hdfff_ffff, 32'h2000_0001, 32'hc000_0000, 1'b0, '0},
    '{5'd24, 32'h0,         32'h4000_0000, 32'h0,         1'b0, '0}
  };

  int phase_level[6] = '{3, 24, 0, 11, 1, 20};

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    cfg_wen    = 1'b0;
    cfg_wdata  = '0;
    errors     = 0;
    cur_level  = LEVEL_RESET;
    send_idle  = 30;
    recv_idle  = 81;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].lvl != cur_level) begin
        in_tvalid <= 1'b0;
        set_level(dir_rows[i].lvl);
      end
      send_vec(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z,
               dir_rows[i].typed, dir_rows[i].idx);
    end

    for (int ph = 0; ph < 6; ph++) begin
      send_idle = (ph < 2) ? 30 : (ph < 4) ? 81 : 0;
      recv_idle = (ph < 2) ? 81 : (ph < 4) ? 30 : 0;
      in_tvalid <= 1'b0;
      set_level(LVL_W'(phase_level[ph]));
      for (int n = 0; n < 115; n++) begin
        if (n == 60) begin
          in_tvalid <= 1'b0;
          drain();
        end
        send_vec(rand_comp(), rand_comp(), rand_comp(), 1'b0, '0);
      end
    end
    in_tvalid <= 1'b0;
    drain();

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/htm_pkg.sv
sv/htm_mul.sv
sv/htm_root.sv
sv/htm_level_cell.sv
sv/htm_point_index.sv
sim/htm_point_index_tb.sv
